FILE: design/bba_pkg.sv
// Shared constants for the bitmap block allocator.
// No dependencies; imported by bba_word_scan and bitmap_block_allocator.
package bba_pkg;

    // Field and register widths.
    localparam int BLK_W        = 13;  // block index incl. one count above the top block
    localparam int NUM_W        = 12;  // width of a reported block number
    localparam int FIRST_W      = 12;  // width of the first data block register
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    // Default parameter values. The bitmap word width must be a power of two.
    localparam int DEF_MAX_BLOCK_COUNT = 4096;
    localparam int DEF_MAP_WORD_BITS   = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA  = 1'd1;

    // Register reset values.
    localparam logic [BLK_W-1:0]   BLOCK_TOTAL_RST = 13'd4096;
    localparam logic [FIRST_W-1:0] FIRST_DATA_RST  = 12'd0;

    // Allocation counter saturates here.
    localparam logic [BLK_W-1:0] COUNT_MAX = 13'h1FFF;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

FILE: design/bba_bitmap_mem.sv
// Bitmap storage of the allocator: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module bba_bitmap_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bba_word_scan.sv
// Find-first-free unit: looks at one bitmap word and returns the lowest free block
// inside the window [lower bound, upper bound). Uses bba_pkg.
module bba_word_scan #(
    parameter int WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS,
    parameter int LOG_W     = $clog2(bba_pkg::DEF_MAP_WORD_BITS),
    parameter int WIW       = bba_pkg::BLK_W - $clog2(bba_pkg::DEF_MAP_WORD_BITS)
) (
    input  logic [WORD_BITS-1:0]    i_word,
    input  logic [WIW-1:0]          i_word_idx,
    input  logic [bba_pkg::BLK_W-1:0] i_lb,
    input  logic [bba_pkg::BLK_W-1:0] i_ub,
    output logic                    o_found,
    output logic [LOG_W-1:0]        o_bit
);
    import bba_pkg::*;

    logic [WIW-1:0]       w_lb_word;
    logic [WIW-1:0]       w_ub_word;
    logic [LOG_W-1:0]     w_lb_bit;
    logic [LOG_W-1:0]     w_ub_bit;
    logic [WORD_BITS-1:0] w_ones;
    logic [WORD_BITS-1:0] w_lo_mask;
    logic [WORD_BITS-1:0] w_up_mask;
    logic [WORD_BITS-1:0] w_free;

    assign w_lb_word = i_lb[BLK_W-1:LOG_W];
    assign w_ub_word = i_ub[BLK_W-1:LOG_W];
    assign w_lb_bit  = i_lb[LOG_W-1:0];
    assign w_ub_bit  = i_ub[LOG_W-1:0];
    assign w_ones    = '1;

    // Window masks: bits at or above the lower bound and below the upper bound.
    always_comb begin
        if (i_word_idx == w_lb_word) begin
            w_lo_mask = w_ones << w_lb_bit;
        end else if (i_word_idx > w_lb_word) begin
            w_lo_mask = w_ones;
        end else begin
            w_lo_mask = '0;
        end

        if (i_word_idx < w_ub_word) begin
            w_up_mask = w_ones;
        end else if (i_word_idx == w_ub_word) begin
            w_up_mask = ~(w_ones << w_ub_bit);
        end else begin
            w_up_mask = '0;
        end
    end

    assign w_free  = ~i_word & w_lo_mask & w_up_mask;
    assign o_found = |w_free;

    // Priority encoder: the lowest free bit wins.
    always_comb begin
        o_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_free[j]) begin
                o_bit = LOG_W'(j);
            end
        end
    end

endmodule

FILE: design/bitmap_block_allocator.sv
// Bitmap block allocator: next-fit search over a used-block bitmap held in memory.
// Depends on bba_pkg, bba_bitmap_mem and bba_word_scan.
//
// Usage:
//   Requests arrive on the s_axis channel, one transaction per block wanted; bit 0
//   of tdata is the new-extent flag. Each request gives exactly one result on the
//   m_axis channel: tdata carries the block number, tuser the status (1 = no free
//   block, block number 0).
//   The cfg channel writes the block total (index 0) and the first data block
//   (index 1) and is always ready; the user must see that it is written only while
//   no request is in flight, as the block does not enforce this.
// Search:
//   A hit on the block right after the last one goes through the READ, CHECK and
//   DONE states and posts its result on the return to IDLE, where the next request
//   is taken. A search reads bitmap words one at a time through a single
//   find-first-free unit. An empty range answers with an error without reading the
//   bitmap. The next request is accepted while the last result waits.
// Reset:
//   The bitmap is cleared by a pass over its MAX_BLOCK_COUNT / MAP_WORD_BITS words (128
//   at the defaults), one word at a time, during which no request is accepted.
// Back-pressure:
//   While m_axis_tready is low the result holds, and a later request waits before
//   posting its result.
module bitmap_block_allocator #(
    parameter int MAX_BLOCK_COUNT = bba_pkg::DEF_MAX_BLOCK_COUNT,
    parameter int MAP_WORD_BITS   = bba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [0] new_extent, [7:1] zero
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bba_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [11:0] block_number, [15:12] zero
    output logic                           m_axis_tuser,  // [0] status
    // Configuration writes.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    localparam int LOG_W = $clog2(MAP_WORD_BITS);
    localparam int WIW   = BLK_W - LOG_W;
    localparam int DEPTH = (MAX_BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Which window is being searched.
    typedef enum logic [1:0] {
        PH_NEXT  = 2'd0,
        PH_UPPER = 2'd1,
        PH_LOWER = 2'd2
    } t_phase;

    // Control registers.
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [BLK_W-1:0]   r_total, n_total;
    logic [FIRST_W-1:0] r_first, n_first;
    logic [NUM_W-1:0]   r_prev, n_prev;
    logic               r_pv, n_pv;
    logic [BLK_W-1:0]   r_count, n_count;
    logic               r_ov, n_ov;

    // Payload registers.
    t_phase             r_phase, n_phase;
    logic [BLK_W-1:0]   r_lb, n_lb;
    logic [BLK_W-1:0]   r_ub, n_ub;
    logic [BLK_W-1:0]   r_cand0, n_cand0;
    logic [WIW-1:0]     r_word, n_word;
    logic [NUM_W-1:0]   r_res_blk, n_res_blk;
    logic               r_res_err, n_res_err;
    logic [NUM_W-1:0]   r_out_blk, n_out_blk;
    logic               r_out_err, n_out_err;

    // Datapath signals.
    logic [BLK_W-1:0]         w_limit;
    logic [BLK_W-1:0]         w_lo;
    logic [BLK_W-1:0]         w_next;
    logic [BLK_W-1:0]         w_start;
    logic [BLK_W-1:0]         w_cand0;
    logic                     w_range_ok;
    logic                     w_contig;
    logic [BLK_W-1:0]         w_ub_m1;
    logic [WIW-1:0]           w_last_word;
    logic [BLK_W-1:0]         w_blk;
    logic                     w_out_free;
    logic                     w_accept;
    logic [WIW+AW-1:0]        w_word_ext;
    logic [AW-1:0]            w_word_addr;
    logic [MAP_WORD_BITS-1:0] w_rdata;
    logic [MAP_WORD_BITS-1:0] w_onehot;
    logic                     w_found;
    logic [LOG_W-1:0]         w_bit;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [MAP_WORD_BITS-1:0] w_wdata;
    logic                     w_re;

    // Allocatable range and the two places a request may start from.
    always_comb begin
        if (32'(r_total) > 32'(MAX_BLOCK_COUNT)) begin
            w_limit = BLK_W'(MAX_BLOCK_COUNT);
        end else begin
            w_limit = r_total;
        end
        w_lo       = {1'b0, r_first};
        w_range_ok = (w_lo < w_limit);
        w_next     = r_pv ? ({1'b0, r_prev} + BLK_W'(1)) : w_lo;
        w_start    = r_pv ? ({1'b0, r_prev} + BLK_W'(2)) : (w_lo + BLK_W'(1));
        w_contig   = !s_axis_tdata[0] && (w_next >= w_lo) && (w_next < w_limit);
        w_cand0    = ((w_start >= w_lo) && (w_start < w_limit)) ? w_start : w_lo;
    end

    assign w_ub_m1     = r_ub - BLK_W'(1);
    assign w_last_word = w_ub_m1[BLK_W-1:LOG_W];
    assign w_blk       = {r_word, w_bit};
    assign w_word_ext  = {{AW{1'b0}}, r_word};
    assign w_word_addr = w_word_ext[AW-1:0];
    assign w_onehot    = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << w_bit;
    assign w_out_free  = !r_ov || m_axis_tready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // Bitmap memory ports: clearing pass, marking a found block, reading words.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_word_addr;
        w_wdata = w_rdata | w_onehot;
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == ST_CHECK && w_found) begin
            w_we = 1'b1;
        end
    end

    assign w_re = (r_state == ST_READ);

    bba_bitmap_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MAP_WORD_BITS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_word_addr),
        .o_rdata (w_rdata)
    );

    bba_word_scan #(
        .WORD_BITS (MAP_WORD_BITS),
        .LOG_W     (LOG_W),
        .WIW       (WIW)
    ) u_scan (
        .i_word     (w_rdata),
        .i_word_idx (r_word),
        .i_lb       (r_lb),
        .i_ub       (r_ub),
        .o_found    (w_found),
        .o_bit      (w_bit)
    );

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_total   = r_total;
        n_first   = r_first;
        n_prev    = r_prev;
        n_pv      = r_pv;
        n_count   = r_count;
        n_ov      = r_ov;
        n_phase   = r_phase;
        n_lb      = r_lb;
        n_ub      = r_ub;
        n_cand0   = r_cand0;
        n_word    = r_word;
        n_res_blk = r_res_blk;
        n_res_err = r_res_err;
        n_out_blk = r_out_blk;
        n_out_err = r_out_err;

        // Configuration writes.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLOCK_TOTAL: n_total = i_cfg_data[BLK_W-1:0];
                REG_FIRST_DATA:  n_first = i_cfg_data[FIRST_W-1:0];
                default: ;
            endcase
        end

        // Output register drains on a completed transaction.
        if (m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (w_accept) begin
                    n_cand0 = w_cand0;
                    if (!w_range_ok) begin
                        n_res_blk = '0;
                        n_res_err = STATUS_ERR;
                        n_state   = ST_DONE;
                    end else if (w_contig) begin
                        n_phase = PH_NEXT;
                        n_lb    = w_next;
                        n_ub    = w_next + BLK_W'(1);
                        n_word  = w_next[BLK_W-1:LOG_W];
                        n_state = ST_READ;
                    end else begin
                        n_phase = PH_UPPER;
                        n_lb    = w_cand0;
                        n_ub    = w_limit;
                        n_word  = w_cand0[BLK_W-1:LOG_W];
                        n_state = ST_READ;
                    end
                end
            end

            ST_READ: begin
                n_state = ST_CHECK;
            end

            ST_CHECK: begin
                if (w_found) begin
                    // Block taken: remember it and count it.
                    n_prev    = w_blk[NUM_W-1:0];
                    n_pv      = 1'b1;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + BLK_W'(1);
                    end
                    n_res_blk = w_blk[NUM_W-1:0];
                    n_res_err = STATUS_OK;
                    n_state   = ST_DONE;
                end else if (r_word != w_last_word) begin
                    n_word  = r_word + WIW'(1);
                    n_state = ST_READ;
                end else begin
                    // Window exhausted: move on to the next one or give up.
                    case (r_phase)
                        PH_NEXT: begin
                            n_phase = PH_UPPER;
                            n_lb    = r_cand0;
                            n_ub    = w_limit;
                            n_word  = r_cand0[BLK_W-1:LOG_W];
                            n_state = ST_READ;
                        end
                        PH_UPPER: begin
                            if (r_cand0 == w_lo) begin
                                n_res_blk = '0;
                                n_res_err = STATUS_ERR;
                                n_state   = ST_DONE;
                            end else begin
                                n_phase = PH_LOWER;
                                n_lb    = w_lo;
                                n_ub    = r_cand0;
                                n_word  = w_lo[BLK_W-1:LOG_W];
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            n_res_blk = '0;
                            n_res_err = STATUS_ERR;
                            n_state   = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DONE: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_out_blk = r_res_blk;
                    n_out_err = r_res_err;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_total <= BLOCK_TOTAL_RST;
            r_first <= FIRST_DATA_RST;
            r_prev  <= '0;
            r_pv    <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_first <= n_first;
            r_prev  <= n_prev;
            r_pv    <= n_pv;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_lb      <= n_lb;
        r_ub      <= n_ub;
        r_cand0   <= n_cand0;
        r_word    <= n_word;
        r_res_blk <= n_res_blk;
        r_res_err <= n_res_err;
        r_out_blk <= n_out_blk;
        r_out_err <= n_out_err;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(M_TDATA_W - NUM_W){1'b0}}, r_out_blk};
    assign m_axis_tuser  = r_out_err;
    assign o_cfg_ready   = 1'b1;

endmodule
